// ===== hw/rtl/htg_pkg.sv =====
// Shared types, codes and color tables for the hue to GRB palette unit.
// Used by htg_color and hue_to_grb_palette_unit; depends on nothing.
package htg_pkg;

   // Palette selection codes
   typedef enum logic [2:0] {
      MODE_RAINBOW   = 3'd0,
      MODE_PASTEL    = 3'd1,
      MODE_NEON      = 3'd2,
      MODE_CRANBERRY = 3'd3,
      MODE_BLUEBERRY = 3'd4,
      MODE_MUSCAT    = 3'd5
   } mode_type;

   // Control register indexes
   localparam logic CSR_PALETTE_MODE     = 1'b0;
   localparam logic CSR_BRIGHTNESS_SHIFT = 1'b1;

   localparam int HUE_W   = 9;
   localparam int WHEEL_W = 10;
   localparam int SHIFT_W = 4;
   localparam int GRB_W   = 24;

   // Sector code for a hue of 360 or more
   localparam logic [2:0] SECTOR_NONE = 3'd6;

   typedef logic [GRB_W-1:0] grb_type;

   // Sector of a wheel hue: 60-degree slices, SECTOR_NONE from 360 up
   function automatic logic [2:0] hue_sector(input logic [WHEEL_W-1:0] h);
      logic [2:0] s;
      if (h < 10'd60)       s = 3'd0;
      else if (h < 10'd120) s = 3'd1;
      else if (h < 10'd180) s = 3'd2;
      else if (h < 10'd240) s = 3'd3;
      else if (h < 10'd300) s = 3'd4;
      else if (h < 10'd360) s = 3'd5;
      else                  s = SECTOR_NONE;
      return s;
   endfunction

   // Fixed palettes, entries packed green, red, blue
   function automatic grb_type fixed_color(input logic [2:0] mode, input logic [2:0] sector);
      grb_type c;
      c = '0;
      case (mode)
         MODE_NEON: begin
            case (sector)
               3'd0: c = 24'h00FF00;
               3'd1: c = 24'hFFFF00;
               3'd2: c = 24'h0000FF;
               3'd3: c = 24'h0080FF;
               3'd4: c = 24'h00FFFF;
               3'd5: c = 24'h00FF80;
               default: c = '0;
            endcase
         end
         MODE_CRANBERRY: begin
            case (sector)
               3'd0: c = 24'h00FF00;
               3'd1: c = 24'h40FF00;
               3'd2: c = 24'h80FF00;
               3'd3: c = 24'h40FF00;
               3'd4: c = 24'h00FF40;
               3'd5: c = 24'h00FF64;
               default: c = '0;
            endcase
         end
         MODE_BLUEBERRY: begin
            case (sector)
               3'd0: c = 24'h0000FF;
               3'd1: c = 24'h0080FF;
               3'd2: c = 24'h00C0FF;
               3'd3: c = 24'h8000FF;
               3'd4: c = 24'hC000FF;
               3'd5: c = 24'h2000FF;
               default: c = '0;
            endcase
         end
         MODE_MUSCAT: begin
            case (sector)
               3'd0: c = 24'hFF0000;
               3'd1: c = 24'hFF0040;
               3'd2: c = 24'hFF0080;
               3'd3: c = 24'hFF4000;
               3'd4: c = 24'hFF8000;
               3'd5: c = 24'hFF0000;
               default: c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/htg_color.sv =====
// Combinational hue to GRB color: wheel, pastel fold, fixed palettes, dimming.
// Depends on htg_pkg.
module htg_color (
   input  logic [htg_pkg::HUE_W-1:0]   hue,
   input  logic [2:0]                  palette_mode,
   input  logic [htg_pkg::SHIFT_W-1:0] brightness_shift,
   output htg_pkg::grb_type            grb_word
);
   import htg_pkg::*;

   logic [WHEEL_W-1:0] hue_wide;
   logic [WHEEL_W-1:0] hue_dbl;
   logic [WHEEL_W-1:0] wheel_hue;
   logic [2:0]         wheel_sector;
   logic [2:0]         raw_sector;
   logic [WHEEL_W-1:0] ramp_diff;
   logic [5:0]         ramp_arg;
   logic [9:0]         ramp_prod;
   logic [7:0]         ramp_val;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   grb_type            color;

   // Fold the doubled hue back once for the pastel wheel
   always_comb begin
      hue_wide = {1'b0, hue};
      hue_dbl  = {hue, 1'b0};
      if (palette_mode == MODE_PASTEL) begin
         wheel_hue = (hue_dbl >= 10'd360) ? hue_dbl - 10'd360 : hue_dbl;
      end else begin
         wheel_hue = hue_wide;
      end
      wheel_sector = hue_sector(wheel_hue);
      raw_sector   = hue_sector(hue_wide);
   end

   // Ramp offset within the sector, then offset*255/60 as offset*17/4
   always_comb begin
      case (wheel_sector)
         3'd0:    ramp_diff = wheel_hue;
         3'd1:    ramp_diff = 10'd120 - wheel_hue;
         3'd2:    ramp_diff = wheel_hue - 10'd120;
         3'd3:    ramp_diff = 10'd240 - wheel_hue;
         3'd4:    ramp_diff = wheel_hue - 10'd240;
         3'd5:    ramp_diff = 10'd360 - wheel_hue;
         default: ramp_diff = '0;
      endcase
      ramp_arg  = ramp_diff[5:0];
      ramp_prod = {ramp_arg, 4'b0000} + {4'b0000, ramp_arg};
      ramp_val  = ramp_prod[9:2];
   end

   // Pick channels by sector for the wheel, or a fixed palette entry
   always_comb begin
      red   = '0;
      green = '0;
      blue  = '0;
      color = '0;
      if (palette_mode == MODE_RAINBOW || palette_mode == MODE_PASTEL) begin
         case (wheel_sector)
            3'd0: begin red = 8'hFF;    green = ramp_val; end
            3'd1: begin red = ramp_val; green = 8'hFF;    end
            3'd2: begin green = 8'hFF;  blue = ramp_val;  end
            3'd3: begin green = ramp_val; blue = 8'hFF;   end
            3'd4: begin red = ramp_val; blue = 8'hFF;     end
            3'd5: begin red = 8'hFF;    blue = ramp_val;  end
            default: ;
         endcase
         color = {green, red, blue};
      end else begin
         color = fixed_color(palette_mode, raw_sector);
      end
   end

   // Dim each channel; a shift of 8 or more clears it
   always_comb begin
      if (brightness_shift[3]) begin
         grb_word = '0;
      end else begin
         grb_word = {color[23:16] >> brightness_shift[2:0],
                     color[15:8]  >> brightness_shift[2:0],
                     color[7:0]   >> brightness_shift[2:0]};
      end
   end

endmodule

// ===== hw/rtl/hue_to_grb_palette_unit.sv =====
// Top level of the hue to GRB palette unit: handshakes, control registers,
// input and result registers around htg_color. Depends on htg_pkg, htg_color.
//
//   channel   direction  payload
//   req_*     in         tdata[8:0] hue
//   rsp_*     out        tdata[23:0] grb_word
//   csr_*     in         index 0 palette_mode, 1 brightness_shift
//
// One hue per cycle while the result is not stalled. A req transfer loads the input
// register; the color logic fills the result register once that is free, and
// rsp_tvalid rises when the result register holds the new color.
// Reset clears the valid flags and sets both control registers to zero.
// A stalled result holds; the input stage still fills,
// and req_tready drops only when both stages are full and rsp_tready is low.
module hue_to_grb_palette_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] hue, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] grb_word
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);
   import htg_pkg::*;

   logic [2:0]         mode_ff;
   logic [2:0]         mode_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [HUE_W-1:0]   s1_hue_ff;
   logic [HUE_W-1:0]   s1_hue_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   grb_type            out_data_ff;
   grb_type            out_data_in;
   grb_type            color;
   logic               out_free;
   logic               s1_adv;
   logic               req_fire;

   // Control register writes
   assign csr_ready = 1'b1;
   always_comb begin
      mode_in  = mode_ff;
      shift_in = shift_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PALETTE_MODE:     mode_in  = csr_data[2:0];
            CSR_BRIGHTNESS_SHIFT: shift_in = csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
      s1_hue_in    = req_fire ? req_tdata[HUE_W-1:0] : s1_hue_ff;
      out_valid_in = s1_adv || (out_valid_ff && !rsp_tready);
      out_data_in  = s1_adv ? color : out_data_ff;
   end

   htg_color u_color (
      .hue              (s1_hue_ff),
      .palette_mode     (mode_ff),
      .brightness_shift (shift_ff),
      .grb_word         (color)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RAINBOW;
         shift_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         shift_ff     <= shift_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_hue_ff   <= s1_hue_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTH
   // A full input stage with a free result register moves on
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("input stage did not advance into result register");

   // A stalled result is never dropped
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff)
      else $error("stalled result lost");

   // Never take a transfer into a full input stage that cannot drain
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && s1_valid_ff && !s1_adv))
      else $error("input stage overrun");
`endif

endmodule
